// ----- src/nsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_pkg
// shared constants, types and character helpers for the sentence checker
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int unsigned MAX_SENTENCE = 127;
    localparam logic [7:0]  MAX_COUNT    = 8'(MAX_SENTENCE);
    localparam logic [7:0]  TITLE_LEN    = 8'd5;

    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_A      = 8'd65;
    localparam logic [7:0] CH_F      = 8'd70;
    localparam logic [7:0] HEX_GAP   = 8'd7;

    localparam logic [2:0] TYPE_PZMAE   = 3'd0;
    localparam logic [2:0] TYPE_PZMAF   = 3'd1;
    localparam logic [2:0] TYPE_PZMAG   = 3'd2;
    localparam logic [2:0] TYPE_PZMA0   = 3'd3;
    localparam logic [2:0] TYPE_UNKNOWN = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_BAD_HEX  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [2:0] sentence_type;
        logic [1:0] status;
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
    } t_result;

    // character of title k at position pos (pos 0..4)
    function automatic logic [7:0] title_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = 8'h50;
            3'd1: c = 8'h5A;
            3'd2: c = 8'h4D;
            3'd3: c = 8'h41;
            3'd4: begin
                case (k)
                    2'd0:    c = 8'h45;
                    2'd1:    c = 8'h46;
                    2'd2:    c = 8'h47;
                    default: c = 8'h30;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // upper-case hex digit value, zero when invalid
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_A && c <= CH_F) begin
            d = c - CH_ZERO - HEX_GAP;
        end
        return d[3:0];
    endfunction

    function automatic logic hex_bad(input logic [7:0] c);
        return !((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A && c <= CH_F));
    endfunction

endpackage

// ----- src/nsc_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_parser
// per-byte sentence state: phase, running xor, title match, count, hex digits
// ----------------------------------------------------------------------------
module nsc_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output nsc_pkg::t_result o_res
);
    import nsc_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_HEX1 = 2'd2;
    localparam logic [1:0] PH_HEX2 = 2'd3;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_xor, n_xor;
    logic [3:0] r_match, n_match;
    logic [7:0] r_count, n_count;
    logic [3:0] r_high, n_high;
    logic       r_hex_err, n_hex_err;

    logic [2:0] w_type;
    logic [7:0] w_rx;

    always_comb begin
        w_type = TYPE_UNKNOWN;
        if (r_count >= TITLE_LEN) begin
            if (r_match[0]) begin
                w_type = TYPE_PZMAE;
            end else if (r_match[1]) begin
                w_type = TYPE_PZMAF;
            end else if (r_match[2]) begin
                w_type = TYPE_PZMAG;
            end else if (r_match[3]) begin
                w_type = TYPE_PZMA0;
            end
        end
    end

    assign w_rx = {r_high, hex_val(i_byte)};

    always_comb begin
        n_phase   = r_phase;
        n_xor     = r_xor;
        n_match   = r_match;
        n_count   = r_count;
        n_high    = r_high;
        n_hex_err = r_hex_err;
        o_res_valid         = 1'b0;
        o_res.sentence_type = w_type;
        o_res.status        = ST_OK;
        o_res.received_sum  = w_rx;
        o_res.computed_sum  = r_xor;
        if (i_en) begin
            if (i_byte == CH_DOLLAR) begin
                n_phase   = PH_BODY;
                n_xor     = 8'h00;
                n_match   = 4'hF;
                n_count   = 8'h00;
                n_high    = 4'h0;
                n_hex_err = 1'b0;
            end else begin
                case (r_phase)
                    PH_BODY: begin
                        if (i_byte == CH_STAR) begin
                            n_phase = PH_HEX1;
                        end else if (r_count >= MAX_COUNT) begin
                            o_res_valid        = 1'b1;
                            o_res.status       = ST_TOO_LONG;
                            o_res.received_sum = 8'h00;
                            n_phase            = PH_IDLE;
                        end else begin
                            if (r_count < TITLE_LEN) begin
                                for (int k = 0; k < 4; k++) begin
                                    if (title_char(2'(k), r_count[2:0]) != i_byte) begin
                                        n_match[k] = 1'b0;
                                    end
                                end
                            end
                            n_xor   = r_xor ^ i_byte;
                            n_count = r_count + 8'd1;
                        end
                    end
                    PH_HEX1: begin
                        n_high    = hex_val(i_byte);
                        n_hex_err = hex_bad(i_byte);
                        n_phase   = PH_HEX2;
                    end
                    PH_HEX2: begin
                        o_res_valid = 1'b1;
                        if (r_hex_err || hex_bad(i_byte)) begin
                            o_res.status = ST_BAD_HEX;
                        end else if (w_rx != r_xor) begin
                            o_res.status = ST_MISMATCH;
                        end
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_xor     <= 8'h00;
            r_match   <= 4'hF;
            r_count   <= 8'h00;
            r_high    <= 4'h0;
            r_hex_err <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_xor     <= n_xor;
            r_match   <= n_match;
            r_count   <= n_count;
            r_high    <= n_high;
            r_hex_err <= n_hex_err;
        end
    end

endmodule

// ----- src/nsc_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_out_reg
// result register with valid/ready toward the consumer
// ----------------------------------------------------------------------------
module nsc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load_valid,
    input  nsc_pkg::t_result i_load_res,
    input  logic             i_ready,
    output logic             o_can_load,
    output logic             o_valid,
    output nsc_pkg::t_result o_res
);
    import nsc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load_valid) begin
            r_res <= i_load_res;
        end
    end

endmodule

// ----- src/nmea_sentence_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// checksum and title check of '$TITLE,...*HH' sentences, one byte per transaction
// ----------------------------------------------------------------------------
// One byte is taken per clock when the result side is not stalled. A byte goes
// into an input register and is evaluated against the sentence state once the
// output register can load, and any result is loaded into the output register
// in that same cycle; a stall holds the byte in the input register.
// A result appears after the second checksum digit, or at once when a body grows
// past MAX_SENTENCE bytes.
// A '$' always restarts parsing and drops an unfinished sentence silently.
module nmea_sentence_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_sentence_type,
    output logic [1:0] o_status,
    output logic [7:0] o_received_sum,
    output logic [7:0] o_computed_sum
);
    import nsc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_can_load;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    assign o_ready = !r_in_valid || w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    nsc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (r_in_valid && w_can_load),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    nsc_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (w_res_valid && r_in_valid),
        .i_load_res   (w_res),
        .i_ready      (i_ready),
        .o_can_load   (w_can_load),
        .o_valid      (o_valid),
        .o_res        (w_out)
    );

    assign o_sentence_type = w_out.sentence_type;
    assign o_status        = w_out.status;
    assign o_received_sum  = w_out.received_sum;
    assign o_computed_sum  = w_out.computed_sum;

endmodule

// ----- src/nsc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_checker
// port-level checks of the sentence checker results
// ----------------------------------------------------------------------------
module nsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_sentence_type,
    input logic [1:0] o_status,
    input logic [7:0] o_received_sum,
    input logic [7:0] o_computed_sum
);
    import nsc_pkg::*;

    // stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_computed_sum) && $stable(o_received_sum))
        else $error("result changed while stalled");

    a_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sentence_type <= TYPE_UNKNOWN)
        else $error("sentence type out of range");

    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_received_sum == o_computed_sum)
        else $error("ok status with differing sums");

    a_mismatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_MISMATCH |-> o_received_sum != o_computed_sum)
        else $error("mismatch status with equal sums");

    a_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_TOO_LONG |-> o_received_sum == 8'h00)
        else $error("too-long result with nonzero received sum");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (.*);
